[hdl/brle_pkg.sv]
package brle_pkg;

  // frame limits and field widths
  localparam int          CUR_W      = 13;
  localparam int          COORD_W    = 12;
  localparam int          CFG_DATA_W = 13;
  localparam logic [12:0] MAX_WIDTH  = 13'd4096;
  localparam logic [12:0] MAX_HEIGHT = 13'd4096;

  // command queue between parser and segment unit (depth a power of two)
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // configuration register indexes
  localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_NIBBLE_MODE  = 2'd2;
  localparam logic [1:0] CFG_TOP_DOWN     = 2'd3;

  // escape codes after a zero count byte
  localparam logic [7:0] OP_EOL   = 8'd0;
  localparam logic [7:0] OP_EOB   = 8'd1;
  localparam logic [7:0] OP_DELTA = 8'd2;

  typedef enum logic [1:0] {
    KIND_SEGMENT = 2'd0,
    KIND_EOB     = 2'd1,
    KIND_TRUNC   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    PH_COUNT = 3'd0,
    PH_VALUE = 3'd1,
    PH_DX    = 3'd2,
    PH_DY    = 3'd3,
    PH_LIT   = 3'd4,
    PH_PAD   = 3'd5
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
    logic       last_byte;
  } in_req_t;

  typedef struct packed {
    kind_t              kind;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] out_row;
    logic [7:0]         pixel_count;
    logic [7:0]         even_index;
    logic [7:0]         odd_index;
  } out_res_t;

  // raw segment or mark from the parser, not yet clipped
  typedef struct packed {
    kind_t            kind;
    logic [CUR_W-1:0] col;
    logic [CUR_W-1:0] row;
    logic [7:0]       cnt;
    logic [7:0]       even_idx;
    logic [7:0]       odd_idx;
  } cmd_t;

  // effective frame geometry and mode
  typedef struct packed {
    logic [CUR_W-1:0] eff_w;
    logic [CUR_W-1:0] eff_h;
    logic             nibble_mode;
    logic             top_down;
  } geom_t;

endpackage

[hdl/brle_front.sv]
module brle_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  brle_pkg::in_req_t req,
  input  brle_pkg::geom_t geom,
  output logic            push,
  output brle_pkg::cmd_t  cmd
);
  import brle_pkg::*;

  phase_t           phase, phase_next;
  logic [CUR_W-1:0] col, col_next;
  logic [CUR_W-1:0] row, row_next;
  logic [7:0]       run_len, run_len_next;
  logic [7:0]       lit_left, lit_left_next;
  logic             pad, pad_next;
  logic [7:0]       dx, dx_next;
  logic             fin, fin_next;

  // state as seen after an optional frame start
  phase_t           cur_phase;
  logic [CUR_W-1:0] cur_col, cur_row;
  logic [7:0]       cur_run, cur_lit, cur_dx;
  logic             cur_pad, cur_fin;

  logic [7:0]       b;
  logic             four;
  logic             cmd_valid;
  logic             do_clamp, eol;
  logic [7:0]       col_add, row_add, n;
  logic [CUR_W-1:0] col_sum, row_sum;
  logic [8:0]       b_plus;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_COUNT;
      col      <= '0;
      row      <= '0;
      run_len  <= '0;
      lit_left <= '0;
      pad      <= 1'b0;
      dx       <= '0;
      fin      <= 1'b0;
    end else if (accept) begin
      phase    <= phase_next;
      col      <= col_next;
      row      <= row_next;
      run_len  <= run_len_next;
      lit_left <= lit_left_next;
      pad      <= pad_next;
      dx       <= dx_next;
      fin      <= fin_next;
    end
  end

  always_comb begin
    b    = req.data_byte;
    four = geom.nibble_mode;

    if (req.frame_start) begin
      cur_phase = PH_COUNT;
      cur_col   = '0;
      cur_row   = '0;
      cur_run   = '0;
      cur_lit   = '0;
      cur_pad   = 1'b0;
      cur_dx    = '0;
      cur_fin   = 1'b0;
    end else begin
      cur_phase = phase;
      cur_col   = col;
      cur_row   = row;
      cur_run   = run_len;
      cur_lit   = lit_left;
      cur_pad   = pad;
      cur_dx    = dx;
      cur_fin   = fin;
    end

    phase_next    = cur_phase;
    run_len_next  = cur_run;
    lit_left_next = cur_lit;
    pad_next      = cur_pad;
    dx_next       = cur_dx;
    fin_next      = cur_fin;
    do_clamp      = 1'b0;
    eol           = 1'b0;
    col_add       = '0;
    row_add       = '0;
    n             = 8'd1;
    b_plus        = {1'b0, b} + 9'd1;
    cmd_valid     = 1'b0;
    cmd           = '0;
    cmd.kind      = KIND_SEGMENT;
    cmd.col       = cur_col;
    cmd.row       = cur_row;

    if (!cur_fin) begin
      case (cur_phase)
        PH_COUNT: begin
          run_len_next = b;
          phase_next   = PH_VALUE;
        end
        PH_VALUE: begin
          phase_next = PH_COUNT;
          if (cur_run != 8'd0) begin
            cmd_valid    = 1'b1;
            cmd.cnt      = cur_run;
            cmd.even_idx = four ? {4'd0, b[7:4]} : b;
            cmd.odd_idx  = four ? {4'd0, b[3:0]} : b;
            col_add      = cur_run;
            do_clamp     = 1'b1;
          end else if (b == OP_EOL) begin
            eol      = 1'b1;
            row_add  = 8'd1;
            do_clamp = 1'b1;
          end else if (b == OP_EOB) begin
            fin_next  = 1'b1;
            cmd_valid = 1'b1;
            cmd       = '0;
            cmd.kind  = KIND_EOB;
          end else if (b == OP_DELTA) begin
            phase_next = PH_DX;
          end else begin
            // literal run; pad to an even number of stream bytes
            lit_left_next = b;
            pad_next      = four ? b_plus[1] : b[0];
            phase_next    = PH_LIT;
          end
        end
        PH_DX: begin
          dx_next    = b;
          phase_next = PH_DY;
        end
        PH_DY: begin
          col_add    = cur_dx;
          row_add    = b;
          do_clamp   = 1'b1;
          phase_next = PH_COUNT;
        end
        PH_LIT: begin
          if (four) begin
            n = (cur_lit[7:1] != 7'd0) ? 8'd2 : cur_lit;
          end
          cmd_valid     = 1'b1;
          cmd.cnt       = n;
          cmd.even_idx  = four ? {4'd0, b[7:4]} : b;
          cmd.odd_idx   = four ? {4'd0, b[3:0]} : b;
          col_add       = n;
          lit_left_next = (cur_lit >= n) ? cur_lit - n : 8'd0;
          if (lit_left_next == 8'd0) begin
            if (cur_pad) begin
              phase_next = PH_PAD;
            end else begin
              do_clamp   = 1'b1;
              phase_next = PH_COUNT;
            end
          end
        end
        default: begin
          pad_next   = 1'b0;
          do_clamp   = 1'b1;
          phase_next = PH_COUNT;
        end
      endcase
    end

    col_sum = (eol ? '0 : cur_col) + {{(CUR_W-8){1'b0}}, col_add};
    row_sum = cur_row + {{(CUR_W-8){1'b0}}, row_add};
    if (do_clamp) begin
      col_next = (col_sum > geom.eff_w) ? geom.eff_w : col_sum;
      row_next = (row_sum > geom.eff_h) ? geom.eff_h : row_sum;
    end else begin
      col_next = col_sum;
      row_next = row_sum;
    end

    // last byte without end of bitmap replaces any segment
    if (req.last_byte && !fin_next) begin
      fin_next  = 1'b1;
      cmd_valid = 1'b1;
      cmd       = '0;
      cmd.kind  = KIND_TRUNC;
    end

    push = accept && cmd_valid;
  end

endmodule

[hdl/brle_queue.sv]
module brle_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  brle_pkg::cmd_t push_cmd,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output brle_pkg::cmd_t head
);
  import brle_pkg::*;

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] fill, fill_next;

  assign full      = (fill == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (fill != '0);
  assign head      = entries[rd_ptr];

  always_comb begin
    fill_next = fill;
    if (push && !pop) begin
      fill_next = fill + 1'b1;
    end else if (pop && !push) begin
      fill_next = fill - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      fill <= fill_next;
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

[hdl/brle_back.sv]
module brle_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  brle_pkg::cmd_t    q_head,
  input  brle_pkg::geom_t   geom,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output brle_pkg::out_res_t out_data
);
  import brle_pkg::*;

  logic             visible, keep, load;
  logic [CUR_W-1:0] avail, row_map;
  out_res_t         res;

  always_comb begin
    visible = (q_head.row < geom.eff_h) && (q_head.col < geom.eff_w) &&
              (q_head.cnt != 8'd0);
    keep    = (q_head.kind != KIND_SEGMENT) || visible;
    avail   = geom.eff_w - q_head.col;
    row_map = geom.top_down ? q_head.row : geom.eff_h - CUR_W'(1) - q_head.row;

    res = '0;
    res.kind = q_head.kind;
    if (q_head.kind == KIND_SEGMENT) begin
      res.start_x     = q_head.col[COORD_W-1:0];
      res.out_row     = row_map[COORD_W-1:0];
      res.pixel_count = ({{(CUR_W-8){1'b0}}, q_head.cnt} > avail) ? avail[7:0] : q_head.cnt;
      res.even_index  = q_head.even_idx;
      res.odd_index   = q_head.odd_idx;
    end

    pop  = q_valid && (!out_valid || !out_stall);
    load = pop && keep;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= res;
    end
  end

endmodule

[hdl/bitmap_rle_decoder_unit.sv]
// rle8 / rle4 compressed bitmap decoder, one stream byte per request
// input channel: in_valid / in_stall with data_byte, frame_start, last_byte;
//   a request is taken on a clock edge with in_valid high and in_stall low
// output channel: out_valid / out_stall with one result per request at most:
//   a clipped pixel segment, an end-of-bitmap mark or a truncated-stream error
// config: cfg_wr_en writes cfg_data to register cfg_index (frame_width,
//   frame_height, nibble_mode, top_down); write only while the decoder is idle
// throughput: one byte per cycle; the parser takes a byte every cycle as long
//   as the two-entry command queue in front of the segment unit is not full
// path: a taken byte's result passes from the parser into the queue, then
//   through clip and row mapping into the output register
// receiver stall: the output register holds its result, the queue fills, and
//   in_stall rises once both queue entries are occupied
// reset: frame 1x1, rle8, bottom-up; parser waits for a count byte, cursors
//   zero, queue empty, out_valid low
module bitmap_rle_decoder_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [1:0]                      cfg_index,
  input  logic [brle_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  brle_pkg::in_req_t               in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output brle_pkg::out_res_t              out_data
);
  import brle_pkg::*;

  // configuration registers
  logic [CFG_DATA_W-1:0] frame_width;
  logic [CFG_DATA_W-1:0] frame_height;
  logic                  nibble_mode;
  logic                  top_down;

  geom_t geom;
  logic  accept;
  logic  push, pop, q_full, q_valid;
  cmd_t  push_cmd, q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= CFG_DATA_W'(1);
      frame_height <= CFG_DATA_W'(1);
      nibble_mode  <= 1'b0;
      top_down     <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width  <= cfg_data;
        CFG_FRAME_HEIGHT: frame_height <= cfg_data;
        CFG_NIBBLE_MODE:  nibble_mode  <= cfg_data[0];
        CFG_TOP_DOWN:     top_down     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // register values above the frame limit act as the limit
  always_comb begin
    geom.eff_w       = (frame_width > MAX_WIDTH) ? MAX_WIDTH : frame_width;
    geom.eff_h       = (frame_height > MAX_HEIGHT) ? MAX_HEIGHT : frame_height;
    geom.nibble_mode = nibble_mode;
    geom.top_down    = top_down;
  end

  // input side stalls only on a full command queue
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // byte parser: opcode decode, cursor tracking and clamping
  brle_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .req    (in_data),
    .geom   (geom),
    .push   (push),
    .cmd    (push_cmd)
  );

  // decouples the parser from output backpressure
  brle_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (q_head)
  );

  // visibility test, width clip, row mapping and output register
  brle_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .geom      (geom),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
